[sv/hlmd_pkg.sv]
// ----------------------------------------------------------------------------
// hlmd_pkg
// Shared widths, operation codes and controller states for the HI/LO
// multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hlmd_pkg;

  // Architectural word width (16 to 32) and fixed port field width
  localparam int WORD_W  = 32;
  localparam int FIELD_W = 32;
  localparam int OP_W    = 3;
  localparam int CNT_W   = $clog2(WORD_W);

  // Operation codes; code 7 has no meaning and behaves as read only
  typedef enum logic [OP_W-1:0] {
    OP_MULT_S  = 3'd0,
    OP_MULT_U  = 3'd1,
    OP_DIV_S   = 3'd2,
    OP_DIV_U   = 3'd3,
    OP_MADD_S  = 3'd4,
    OP_WRITE_LO = 3'd5,
    OP_READ    = 3'd6
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SIGN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[sv/hi_lo_multiply_divide_unit.sv]
// ----------------------------------------------------------------------------
// hi_lo_multiply_divide_unit
// MIPS32 style HI/LO multiply, divide and multiply-accumulate unit.
// ----------------------------------------------------------------------------
// One item is worked at a time. For multiplies, multiply-accumulate and
// divides by a nonzero divisor, operand magnitudes latch at acceptance, then
// a one-bit-per-cycle shift-add / restoring-subtract loop runs over the
// WORD_W bits, a sign-correction step follows, HI:LO is committed (where the
// accumulate add happens) and the result beat is then shown from the output
// register.
// Write lo, read only, the unused code and a divide by zero skip the loop
// and the sign step. The input is stalled while an item is in flight; a
// finished result waits in the output register while the unit takes the
// next item, and a second result is held back until the first beat has gone.
`default_nettype none

module hi_lo_multiply_divide_unit
  import hlmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [FIELD_W-1:0] in_operand_a,
  input  wire logic [FIELD_W-1:0] in_operand_b,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [FIELD_W-1:0]      out_hi_value,
  output logic [FIELD_W-1:0]      out_lo_value,
  output logic                    out_divide_by_zero
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic                neg_lo_r, neg_lo_nxt;
  logic                neg_hi_r, neg_hi_nxt;
  logic                dz_r, dz_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [WORD_W-1:0]   hi_w_r, hi_w_nxt;   // product upper / partial remainder
  logic [WORD_W-1:0]   lo_w_r, lo_w_nxt;   // multiplier / dividend -> quotient
  logic [WORD_W-1:0]   opb_r, opb_nxt;     // multiplicand / divisor
  logic [WORD_W-1:0]   hi_r, hi_nxt;
  logic [WORD_W-1:0]   lo_r, lo_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_dz_r, out_dz_nxt;

  // controller outputs
  logic accept, run_step, sign_step, commit;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  op_t               in_op;
  logic [WORD_W-1:0] a_w, b_w, mag_a, mag_b;
  logic              is_signed, is_mul_in, is_div_in, b_zero, needs_run;

  assign in_op = op_t'(in_operation);
  assign a_w   = in_operand_a[WORD_W-1:0];
  assign b_w   = in_operand_b[WORD_W-1:0];
  assign b_zero = (b_w == '0);

  always_comb begin
    is_signed = 1'b0;
    is_mul_in = 1'b0;
    is_div_in = 1'b0;
    unique case (in_op) inside
      OP_MULT_S, OP_MADD_S: begin
        is_signed = 1'b1;
        is_mul_in = 1'b1;
      end
      OP_MULT_U: is_mul_in = 1'b1;
      OP_DIV_S: begin
        is_signed = 1'b1;
        is_div_in = 1'b1;
      end
      OP_DIV_U: is_div_in = 1'b1;
      default: ;
    endcase
  end

  assign mag_a = (is_signed && a_w[WORD_W-1]) ? (~a_w + 1'b1) : a_w;
  assign mag_b = (is_signed && b_w[WORD_W-1]) ? (~b_w + 1'b1) : b_w;
  assign needs_run = is_mul_in || (is_div_in && !b_zero);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = needs_run ? ST_RUN : ST_DONE;
      ST_RUN:  if (cnt_r == '0) state_nxt = ST_SIGN;
      ST_SIGN: state_nxt = ST_DONE;
      ST_DONE: if (!(out_valid_r && out_stall)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    run_step  = 1'b0;
    sign_step = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_RUN:  run_step  = 1'b1;
      ST_SIGN: sign_step = 1'b1;
      ST_DONE: commit = !(out_valid_r && out_stall);
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Serial datapath: one bit per cycle
  // --------------------------------------------------------------------------
  logic [WORD_W:0]     mul_sum, div_pr, div_diff;
  logic [2*WORD_W-1:0] pair, pair_neg, madd_sum;
  logic                op_is_mul;

  assign op_is_mul = (op_r == OP_MULT_S) || (op_r == OP_MULT_U) || (op_r == OP_MADD_S);
  assign mul_sum  = {1'b0, hi_w_r} + (lo_w_r[0] ? {1'b0, opb_r} : '0);
  assign div_pr   = {hi_w_r, lo_w_r[WORD_W-1]};
  assign div_diff = div_pr - {1'b0, opb_r};
  assign pair     = {hi_w_r, lo_w_r};
  assign pair_neg = ~pair + 1'b1;
  assign madd_sum = {hi_r, lo_r} + pair;

  always_comb begin
    op_nxt     = op_r;
    neg_lo_nxt = neg_lo_r;
    neg_hi_nxt = neg_hi_r;
    dz_nxt     = dz_r;
    cnt_nxt    = cnt_r;
    hi_w_nxt   = hi_w_r;
    lo_w_nxt   = lo_w_r;
    opb_nxt    = opb_r;
    if (accept) begin
      // latch magnitudes and result signs
      op_nxt     = in_op;
      dz_nxt     = is_div_in && b_zero;
      neg_lo_nxt = is_signed && (a_w[WORD_W-1] ^ b_w[WORD_W-1]);
      neg_hi_nxt = is_signed && a_w[WORD_W-1];
      cnt_nxt    = CNT_W'(WORD_W - 1);
      hi_w_nxt   = '0;
      lo_w_nxt   = is_div_in ? mag_a : (is_mul_in ? mag_b : a_w);
      opb_nxt    = is_div_in ? mag_b : mag_a;
    end else if (run_step) begin
      cnt_nxt = cnt_r - 1'b1;
      if (op_is_mul) begin
        // shift-add: low product bits shift in behind the multiplier
        hi_w_nxt = mul_sum[WORD_W:1];
        lo_w_nxt = {mul_sum[0], lo_w_r[WORD_W-1:1]};
      end else begin
        // restoring divide: quotient bits shift in behind the dividend
        hi_w_nxt = div_diff[WORD_W] ? div_pr[WORD_W-1:0] : div_diff[WORD_W-1:0];
        lo_w_nxt = {lo_w_r[WORD_W-2:0], ~div_diff[WORD_W]};
      end
    end else if (sign_step) begin
      if (op_is_mul) begin
        if (neg_lo_r) {hi_w_nxt, lo_w_nxt} = pair_neg;
      end else begin
        if (neg_lo_r) lo_w_nxt = ~lo_w_r + 1'b1;
        if (neg_hi_r) hi_w_nxt = ~hi_w_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // HI/LO commit and result beat
  // --------------------------------------------------------------------------
  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (commit) begin
      unique case (op_r) inside
        OP_MULT_S, OP_MULT_U, OP_DIV_S, OP_DIV_U: begin
          if (!dz_r) begin
            hi_nxt = hi_w_r;
            lo_nxt = lo_w_r;
          end
        end
        OP_MADD_S:   {hi_nxt, lo_nxt} = madd_sum;
        OP_WRITE_LO: lo_nxt = lo_w_r;
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = commit ? 1'b1 : (out_valid_r && out_stall);
  assign out_dz_nxt    = commit ? dz_r : out_dz_r;

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hi_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
      out_dz_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
      out_dz_r    <= out_dz_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    neg_lo_r <= neg_lo_nxt;
    neg_hi_r <= neg_hi_nxt;
    dz_r     <= dz_nxt;
    cnt_r    <= cnt_nxt;
    hi_w_r   <= hi_w_nxt;
    lo_w_r   <= lo_w_nxt;
    opb_r    <= opb_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hi_value       = FIELD_W'(hi_r);
  assign out_lo_value       = FIELD_W'(lo_r);
  assign out_divide_by_zero = out_dz_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the iteration loop always ends in the sign step
  a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r == '0) |=> (state_r == ST_SIGN))
    else $error("iteration loop did not end in the sign step");

  // a finished divide leaves a remainder magnitude below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN && !op_is_mul) |-> (hi_w_r < opb_r))
    else $error("divide remainder not below divisor");

  // divide-by-zero flag only ever belongs to a divide
  a_dz_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && dz_r) |-> (op_r == OP_DIV_S || op_r == OP_DIV_U))
    else $error("divide-by-zero flag on a non-divide");

  // a new result never overwrites a stalled beat
  a_hold_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=>
      (state_r == ST_DONE && $stable(hi_r) && $stable(lo_r)))
    else $error("HI/LO committed while a result beat was stalled");

endmodule

`default_nettype wire
